// File: src/arxp_pkg.sv
// Package with the types, constants and round functions of the ARX permutation unit.
`default_nettype none

package arxp_pkg;

   // One state word and groupings of words.
   typedef logic [31:0]      word_type;
   typedef logic [3:0][31:0] quad_type;
   typedef logic [7:0][31:0] state_type;

   // Request payload: the state before the permutation.
   typedef struct packed {
      word_type in_w7;
      word_type in_w6;
      word_type in_w5;
      word_type in_w4;
      word_type in_w3;
      word_type in_w2;
      word_type in_w1;
      word_type in_w0;
   } arxp_req_type;

   // Response payload: the state after all rounds.
   typedef struct packed {
      word_type out_w7;
      word_type out_w6;
      word_type out_w5;
      word_type out_w4;
      word_type out_w3;
      word_type out_w2;
      word_type out_w1;
      word_type out_w0;
   } arxp_rsp_type;

   // Kinds of pipeline stage within one round.
   localparam int KIND_MIX_XOR = 0;
   localparam int KIND_MIX_ADD = 1;
   localparam int KIND_PERM    = 2;

   // Four mixing steps of two stages each, then the permutation stage.
   localparam int MIX_STEPS        = 4;
   localparam int STAGES_PER_ROUND = 2 * MIX_STEPS + 1;

   // Rotation amounts of the mixing step.
   localparam int unsigned ROT_PRE_BASE  = 7;
   localparam int unsigned ROT_POST_BASE = 9;
   localparam int unsigned MIX_OFFS [0:1][0:3] = '{'{1, 2, 3, 5}, '{7, 11, 13, 17}};

   // Left rotation by a constant amount.
   function automatic word_type rotl32(word_type x, int unsigned n);
      logic [63:0] dbl;
      dbl = {x, x} << n[4:0];
      return dbl[63:32];
   endfunction

   // First half of mixing step j in both halves: xor with the sum, then rotate.
   function automatic state_type mix_pre(state_type w, logic [1:0] j);
      state_type res;
      logic [2:0] ix, ip, iq, ir;
      res = w;
      for (int h = 0; h < 2; h++) begin
         ix = {h[0], j};
         ip = {h[0], j + 2'd1};
         iq = {h[0], j + 2'd2};
         ir = {h[0], j + 2'd3};
         res[ix] = rotl32(w[ix] ^ (w[ip] + w[iq] + w[ir]),
                          ROT_PRE_BASE + MIX_OFFS[h][j]);
      end
      return res;
   endfunction

   // Second half of mixing step j: add the xor of the others, then rotate.
   function automatic state_type mix_post(state_type w, logic [1:0] j);
      state_type res;
      logic [2:0] ix, ip, iq, ir;
      res = w;
      for (int h = 0; h < 2; h++) begin
         ix = {h[0], j};
         ip = {h[0], j + 2'd1};
         iq = {h[0], j + 2'd2};
         ir = {h[0], j + 2'd3};
         res[ix] = rotl32(w[ix] + (w[ip] ^ w[iq] ^ w[ir]),
                          ROT_POST_BASE + MIX_OFFS[h][j]);
      end
      return res;
   endfunction

   // One bit-permutation pass: exchange bits where the key is clear, then rotate.
   function automatic quad_type perm_pass(quad_type a, quad_type k);
      quad_type res;
      word_type diff;
      res = a;
      diff = (res[0] ^ res[1]) & ~k[0];
      res[0] = res[0] ^ diff;
      res[1] = res[1] ^ diff;
      diff = (res[2] ^ res[3]) & ~k[1];
      res[2] = res[2] ^ diff;
      res[3] = res[3] ^ diff;
      res[0] = rotl32(res[0], 1);
      res[1] = rotl32(res[1], 2);
      res[2] = rotl32(res[2], 3);
      res[3] = rotl32(res[3], 5);
      diff = (res[0] ^ res[2]) & ~k[2];
      res[0] = res[0] ^ diff;
      res[2] = res[2] ^ diff;
      diff = (res[1] ^ res[3]) & ~k[3];
      res[1] = res[1] ^ diff;
      res[3] = res[3] ^ diff;
      res[0] = rotl32(res[0], 8);
      res[1] = rotl32(res[1], 16);
      res[2] = rotl32(res[2], 24);
      res[3] = rotl32(res[3], 4);
      return res;
   endfunction

   // Both passes of a round: upper half keyed by the lower, then the reverse.
   function automatic state_type bit_perm(state_type w);
      state_type res;
      res = w;
      res[7:4] = perm_pass(w[7:4], w[3:0]);
      res[3:0] = perm_pass(w[3:0], res[7:4]);
      return res;
   endfunction

endpackage

`default_nettype wire

// File: src/arxp_stage.sv
// One pipeline cell: a registered part of a round with its valid flag.
`default_nettype none

module arxp_stage
   import arxp_pkg::*;
#(
   parameter int KIND    = KIND_MIX_XOR,
   parameter int MIX_IDX = 0
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      up_valid,
   output logic           up_ready,
   input  wire state_type up_data,
   output logic           dn_valid,
   input  wire logic      dn_ready,
   output state_type      dn_data
);

   logic      valid_ff;
   logic      valid_in;
   state_type data_ff;
   state_type data_in;

   // The operation of this cell, fixed at elaboration.
   generate
      if (KIND == KIND_MIX_XOR) begin : g_xor
         assign data_in = mix_pre(up_data, MIX_IDX[1:0]);
      end else if (KIND == KIND_MIX_ADD) begin : g_add
         assign data_in = mix_post(up_data, MIX_IDX[1:0]);
      end else begin : g_perm
         assign data_in = bit_perm(up_data);
      end
   endgenerate

   // The cell takes a transfer when it is empty or its content moves on.
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// File: src/arxp_round_cell.sv
// One full round: four two-stage mixing steps followed by the permutation stage.
`default_nettype none

module arxp_round_cell
   import arxp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      up_valid,
   output logic           up_ready,
   input  wire state_type up_data,
   output logic           dn_valid,
   input  wire logic      dn_ready,
   output state_type      dn_data
);

   logic      valid_chain [0:STAGES_PER_ROUND];
   logic      ready_chain [0:STAGES_PER_ROUND];
   state_type data_chain  [0:STAGES_PER_ROUND];

   assign valid_chain[0] = up_valid;
   assign up_ready       = ready_chain[0];
   assign data_chain[0]  = up_data;

   // Mixing steps: the xor-and-rotate stage, then the add-and-rotate stage.
   for (genvar m = 0; m < MIX_STEPS; m++) begin : g_mix
      arxp_stage #(
         .KIND    (KIND_MIX_XOR),
         .MIX_IDX (m)
      ) u_pre (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_chain[2*m]),
         .up_ready (ready_chain[2*m]),
         .up_data  (data_chain[2*m]),
         .dn_valid (valid_chain[2*m+1]),
         .dn_ready (ready_chain[2*m+1]),
         .dn_data  (data_chain[2*m+1])
      );

      arxp_stage #(
         .KIND    (KIND_MIX_ADD),
         .MIX_IDX (m)
      ) u_post (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_chain[2*m+1]),
         .up_ready (ready_chain[2*m+1]),
         .up_data  (data_chain[2*m+1]),
         .dn_valid (valid_chain[2*m+2]),
         .dn_ready (ready_chain[2*m+2]),
         .dn_data  (data_chain[2*m+2])
      );
   end

   // Both bit-permutation passes of the round.
   arxp_stage #(
      .KIND    (KIND_PERM),
      .MIX_IDX (0)
   ) u_perm (
      .clock    (clock),
      .reset    (reset),
      .up_valid (valid_chain[STAGES_PER_ROUND-1]),
      .up_ready (ready_chain[STAGES_PER_ROUND-1]),
      .up_data  (data_chain[STAGES_PER_ROUND-1]),
      .dn_valid (valid_chain[STAGES_PER_ROUND]),
      .dn_ready (ready_chain[STAGES_PER_ROUND]),
      .dn_data  (data_chain[STAGES_PER_ROUND])
   );

   assign dn_valid                      = valid_chain[STAGES_PER_ROUND];
   assign ready_chain[STAGES_PER_ROUND] = dn_ready;
   assign dn_data                       = data_chain[STAGES_PER_ROUND];

endmodule

`default_nettype wire

// File: src/arx_permutation_256_unit.sv
// Top level of the ARX permutation unit: a chain of round cells.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data  (arxp_req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data  (arxp_rsp_type)
//
// Each round takes nine pipeline stages, and a new item is accepted every cycle
// unless a response-side stall has filled every stage back to the input.
// The last permutation stage of the last round is the output register.
// A stall at the response side holds the unbroken run of full stages next to the
// output; stages behind an empty one keep moving, so transfers continue until
// every stage holds an item.
// Synchronous reset empties all stages.
`default_nettype none

module arx_permutation_256_unit
   import arxp_pkg::*;
#(
   parameter int NUM_ROUNDS = 10
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire arxp_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output arxp_rsp_type      rsp_data
);

   logic      valid_chain [0:NUM_ROUNDS];
   logic      ready_chain [0:NUM_ROUNDS];
   state_type data_chain  [0:NUM_ROUNDS];
   state_type final_state;

   // Unpack the request into state words.
   assign valid_chain[0] = req_valid;
   assign req_ready      = ready_chain[0];
   assign data_chain[0]  = {req_data.in_w7, req_data.in_w6, req_data.in_w5,
                            req_data.in_w4, req_data.in_w3, req_data.in_w2,
                            req_data.in_w1, req_data.in_w0};

   // One cell for each round, each handing its state to the next.
   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
      arxp_round_cell u_round (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_chain[r]),
         .up_ready (ready_chain[r]),
         .up_data  (data_chain[r]),
         .dn_valid (valid_chain[r+1]),
         .dn_ready (ready_chain[r+1]),
         .dn_data  (data_chain[r+1])
      );
   end

   // Pack the final state into the response.
   assign final_state             = data_chain[NUM_ROUNDS];
   assign rsp_valid               = valid_chain[NUM_ROUNDS];
   assign ready_chain[NUM_ROUNDS] = rsp_ready;
   assign rsp_data.out_w0         = final_state[0];
   assign rsp_data.out_w1         = final_state[1];
   assign rsp_data.out_w2         = final_state[2];
   assign rsp_data.out_w3         = final_state[3];
   assign rsp_data.out_w4         = final_state[4];
   assign rsp_data.out_w5         = final_state[5];
   assign rsp_data.out_w6         = final_state[6];
   assign rsp_data.out_w7         = final_state[7];

`ifndef NO_ASSERTIONS
   // With nothing waiting at the output, every stage can take a transfer.
   a_ready_when_out_empty : assert property (
      @(posedge clock) disable iff (reset) !rsp_valid |-> req_ready
   ) else $error("request refused while the output stage is empty");

   // Back-pressure at the input can only come from a stalled output.
   a_stall_source : assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |-> (rsp_valid && !rsp_ready)
   ) else $error("input stalled without a stalled response");

   // Reset leaves no result pending.
   a_reset_empties : assert property (
      @(posedge clock) reset |=> !rsp_valid
   ) else $error("response valid directly after reset");
`endif

endmodule

`default_nettype wire

// File: tb/sv/arx_permutation_256_unit_tb.sv
// Self-checking testbench for the 256-bit ARX permutation unit.
`timescale 1ns / 100ps

module arx_permutation_256_unit_tb
   import arxp_pkg::*;
();

   localparam int unsigned ROUND_COUNT  = 10;
   localparam int unsigned DRAIN_CYCLES = 9 * ROUND_COUNT + 30;
   localparam int unsigned QUIET_LIMIT  = 4000;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned SEGMENTS     = 10;
   localparam int unsigned SEGMENT_ITEMS = 125;

   // Rotation amounts of the mixing step: a base plus a per-word offset.
   localparam int unsigned PRE_ROT  = 7;
   localparam int unsigned POST_ROT = 9;
   localparam int unsigned MIX_SHIFTS [2][4] = '{'{1, 2, 3, 5}, '{7, 11, 13, 17}};

   // Pacing of both sides: none, short gaps only, or a mix of short and long.
   localparam int unsigned PACE_NONE  = 0;
   localparam int unsigned PACE_SHORT = 1;
   localparam int unsigned PACE_MIXED = 2;

   typedef struct packed {
      logic         has_result;
      logic [255:0] stim;
      logic [255:0] result;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   arxp_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   arxp_rsp_type rsp_data;

   arxp_rsp_type permuted_states [$];
   int unsigned  mismatch_count = 0;
   int unsigned  quiet_cycles = 0;
   int unsigned  pacing = PACE_MIXED;

   // Directed rows, words 7 down to 0. Only the all-zero state has an obvious image.
   directed_row_type directed_rows [22] = '{
      '{1'b1, 256'h0, 256'h0},
      '{1'b0, 256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF, '0},
      '{1'b0, 256'h00000000_00000000_00000000_00000000_00000000_00000000_00000000_FFFFFFFF, '0},
      '{1'b0, 256'h00000000_00000000_00000000_00000000_00000000_00000000_FFFFFFFF_00000000, '0},
      '{1'b0, 256'h00000000_00000000_00000000_00000000_00000000_FFFFFFFF_00000000_00000000, '0},
      '{1'b0, 256'h00000000_00000000_00000000_00000000_FFFFFFFF_00000000_00000000_00000000, '0},
      '{1'b0, 256'h00000000_00000000_00000000_FFFFFFFF_00000000_00000000_00000000_00000000, '0},
      '{1'b0, 256'h00000000_00000000_FFFFFFFF_00000000_00000000_00000000_00000000_00000000, '0},
      '{1'b0, 256'h00000000_FFFFFFFF_00000000_00000000_00000000_00000000_00000000_00000000, '0},
      '{1'b0, 256'hFFFFFFFF_00000000_00000000_00000000_00000000_00000000_00000000_00000000, '0},
      '{1'b0, 256'h00000000_00000000_00000000_00000000_00000000_00000000_00000000_80000001, '0},
      '{1'b0, 256'h00000000_00000000_00000000_00000000_00000000_00000000_80000001_00000000, '0},
      '{1'b0, 256'h00000000_00000000_00000000_00000000_00000000_80000001_00000000_00000000, '0},
      '{1'b0, 256'h00000000_00000000_00000000_00000000_80000001_00000000_00000000_00000000, '0},
      '{1'b0, 256'h00000000_00000000_00000000_80000001_00000000_00000000_00000000_00000000, '0},
      '{1'b0, 256'h00000000_00000000_80000001_00000000_00000000_00000000_00000000_00000000, '0},
      '{1'b0, 256'h00000000_80000001_00000000_00000000_00000000_00000000_00000000_00000000, '0},
      '{1'b0, 256'h80000001_00000000_00000000_00000000_00000000_00000000_00000000_00000000, '0},
      '{1'b0, 256'hAAAAAAAA_55555555_AAAAAAAA_55555555_AAAAAAAA_55555555_AAAAAAAA_55555555, '0},
      '{1'b0, 256'h80000000_80000000_80000000_80000000_80000000_80000000_80000000_80000000, '0},
      '{1'b0, 256'h00000007_00000006_00000005_00000004_00000003_00000002_00000001_00000000, '0},
      '{1'b0, 256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_00000000, '0}
   };

   arx_permutation_256_unit #(
      .NUM_ROUNDS (ROUND_COUNT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Free-running clock with a 10 ns period.
   initial begin
      forever #5 clock = ~clock;
   end

   // Reset is held from the start, then released for the rest of the run.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Left rotation; a zero amount leaves the word unchanged.
   function automatic logic [31:0] rot_word(input logic [31:0] x, input int unsigned n);
      return (x << (n % 32)) | (x >> (32 - (n % 32)));
   endfunction

   // One mixing step on a target word, given the other three words of its half.
   function automatic logic [31:0] mix_word(input logic [31:0] x, p, q, r,
                                            input int unsigned shift);
      x = x ^ (p + q + r);
      x = rot_word(x, PRE_ROT + shift);
      x = x + (p ^ q ^ r);
      return rot_word(x, POST_ROT + shift);
   endfunction

   // One bit-shuffle pass: exchange bits between word pairs where the key is
   // clear, with fixed rotations after each exchange.
   function automatic logic [3:0][31:0] shuffle_quad(input logic [3:0][31:0] v,
                                                     input logic [3:0][31:0] key);
      logic [31:0] d;
      d = (v[0] ^ v[1]) & ~key[0];
      v[0] = v[0] ^ d;
      v[1] = v[1] ^ d;
      d = (v[2] ^ v[3]) & ~key[1];
      v[2] = v[2] ^ d;
      v[3] = v[3] ^ d;
      v[0] = rot_word(v[0], 1);
      v[1] = rot_word(v[1], 2);
      v[2] = rot_word(v[2], 3);
      v[3] = rot_word(v[3], 5);
      d = (v[0] ^ v[2]) & ~key[2];
      v[0] = v[0] ^ d;
      v[2] = v[2] ^ d;
      d = (v[1] ^ v[3]) & ~key[3];
      v[1] = v[1] ^ d;
      v[3] = v[3] ^ d;
      v[0] = rot_word(v[0], 8);
      v[1] = rot_word(v[1], 16);
      v[2] = rot_word(v[2], 24);
      v[3] = rot_word(v[3], 4);
      return v;
   endfunction

   // Full permutation of one state, for each round: mixing of both halves, then the
   // two shuffle passes, the second keyed by the freshly shuffled upper half.
   function automatic arxp_rsp_type permute_state(input arxp_req_type item);
      logic [7:0][31:0] s;
      int unsigned      rnd, h, j, base;
      s = item;
      for (rnd = 0; rnd < ROUND_COUNT; rnd++) begin
         for (h = 0; h < 2; h++) begin
            base = 4 * h;
            for (j = 0; j < 4; j++) begin
               s[base + j] = mix_word(s[base + j], s[base + (j + 1) % 4],
                                      s[base + (j + 2) % 4], s[base + (j + 3) % 4],
                                      MIX_SHIFTS[h][j]);
            end
         end
         s[7:4] = shuffle_quad(s[7:4], s[3:0]);
         s[3:0] = shuffle_quad(s[3:0], s[7:4]);
      end
      return arxp_rsp_type'(s);
   endfunction

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pacing == PACE_NONE || pick < 50) begin
         return 0;
      end else if (pick < 90 || pacing == PACE_SHORT) begin
         return $urandom_range(1, 3);
      end else if (pick < 98) begin
         return $urandom_range(4, 20);
      end else begin
         return $urandom_range(50, 200);
      end
   endfunction

   // Random word, biased towards the extremes and single-bit patterns.
   function automatic logic [31:0] random_word();
      logic [31:0] one_hot;
      one_hot = 32'h1 << $urandom_range(0, 31);
      case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2: begin
            return one_hot;
         end
         3: begin
            return ~one_hot;
         end
         default: begin
            return $urandom();
         end
      endcase
   endfunction

   // Present one state after an optional gap and hold it until the transfer,
   // then record the state that should come back for it.
   task automatic send_state(input arxp_req_type item, input logic has_result,
                             input arxp_rsp_type known_result);
      int unsigned gap;
      gap = idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      permuted_states.push_back(has_result ? known_result : permute_state(item));
   endtask

   // Stimulus: the directed table, random segments at each pacing, then the drain.
   initial begin
      logic [7:0][31:0] words;
      int unsigned      row, seg, n, k;
      do @(posedge clock); while (reset);
      for (row = 0; row < $size(directed_rows); row++) begin
         send_state(arxp_req_type'(directed_rows[row].stim), directed_rows[row].has_result,
                    arxp_rsp_type'(directed_rows[row].result));
      end
      for (seg = 0; seg < SEGMENTS; seg++) begin
         pacing = seg % 3;
         for (n = 0; n < SEGMENT_ITEMS; n++) begin
            for (k = 0; k < 8; k++) begin
               words[k] = random_word();
            end
            send_state(arxp_req_type'(words), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;
      while (permuted_states.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Response side: bursts of readiness broken by stalls of random length.
   initial begin
      int unsigned stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_length();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   // Each response transfer is compared word by word with the oldest expected state.
   always @(posedge clock) begin : check_results
      logic [7:0][31:0] want, got;
      int unsigned      w;
      if (!reset && rsp_valid && rsp_ready) begin
         got = rsp_data;
         if (permuted_states.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: response with none expected: %h", $realtime, got);
            end
         end else begin
            want = permuted_states.pop_front();
            for (w = 0; w < 8; w++) begin
               if (got[w] !== want[w]) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: out_w%0d expected %h, got %h",
                              $realtime, w, want[w], got[w]);
                  end
               end
            end
         end
      end
   end

   // Watchdog: too long without any transfer on either side ends the run.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
